// ===== rtl/core/ple_pkg.sv =====
// shared types and codes of the positional list engine
`default_nettype none

package ple_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int ENTRY_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_POS  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_HEAD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REM_TAIL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REM_POS  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [ENTRY_W-1:0]  entry_value;
    } t_cmd;

    typedef struct packed {
        logic [ENTRY_W-1:0]  removed_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } t_res;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } t_shift_op;

endpackage

`default_nettype wire

// ===== rtl/core/positional_list_engine_unit.sv =====
// top level of the positional list engine: cell row, count and result register
`default_nettype none

// Ordered list of up to DEPTH handles. A command is taken on any cycle with
// start high (busy stays low), and its result appears on o_res with o_strobe
// in the cycle after it is taken, so a command may be issued every cycle.
// Inserts and removals at any position complete as the command is taken,
// because the whole row of cells shifts left or right in parallel. The store
// needs no clearing after reset; only the entry count and the strobe are cleared.

module positional_list_engine_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  ple_pkg::t_cmd  i_cmd,
    output logic           o_strobe,
    output ple_pkg::t_res  o_res
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic                   w_fire;
    t_shift_op              w_op;
    t_shift_op              w_cell_op;
    logic [IDX_W-1:0]       w_at;
    logic [STATUS_W-1:0]    w_status;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_q [DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_res             r_res;
    t_res             n_res;

    assign busy      = 1'b0;
    assign w_fire    = start && !busy;
    assign w_cell_op = w_fire ? w_op : OP_HOLD;
    assign w_value   = VALUE_WIDTH'(i_cmd.entry_value);

    ple_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_cmd    (i_cmd),
        .i_count  (r_count),
        .o_op     (w_op),
        .o_at     (w_at),
        .o_status (w_status)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_q[g+1];
        end

        ple_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX_W       (IDX_W),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_at    (w_at),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_q[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cell_op == OP_INSERT) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cell_op == OP_REMOVE) begin
            n_count = r_count - CNT_W'(1);
        end
        n_res.removed_value = '0;
        if (w_op == OP_REMOVE) begin
            n_res.removed_value = ENTRY_W'(w_q[w_at]);
        end
        n_res.status      = w_status;
        n_res.entry_count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_fire;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/ple_cell.sv =====
// one storage cell of the shifting list row
`default_nettype none

module ple_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int IDX         = 0
) (
    input  wire                      i_clk,
    input  ple_pkg::t_shift_op       i_op,
    input  wire  [IDX_W-1:0]         i_at,
    input  wire  [VALUE_WIDTH-1:0]   i_value,
    input  wire  [VALUE_WIDTH-1:0]   i_left,
    input  wire  [VALUE_WIDTH-1:0]   i_right,
    output logic [VALUE_WIDTH-1:0]   o_q
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_q;
    logic [VALUE_WIDTH-1:0] n_q;

    always_comb begin
        n_q = r_q;
        unique case (i_op)
            OP_INSERT: begin
                if (MY_IDX > i_at) begin
                    n_q = i_left;
                end else if (MY_IDX == i_at) begin
                    n_q = i_value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_at) begin
                    n_q = i_right;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/ple_ctrl.sv =====
// command decode: range, empty and full checks and the shift plan
`default_nettype none

module ple_ctrl #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5,
    parameter int IDX_W = 4
) (
    input  ple_pkg::t_cmd                i_cmd,
    input  wire  [CNT_W-1:0]             i_count,
    output ple_pkg::t_shift_op           o_op,
    output logic [IDX_W-1:0]             o_at,
    output logic [ple_pkg::STATUS_W-1:0] o_status
);
    import ple_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_at;
    logic             w_full;
    logic             w_empty;

    assign w_cnt   = CMP_W'(i_count);
    assign w_pos   = CMP_W'(i_cmd.position);
    assign w_full  = (i_count == CNT_W'(DEPTH));
    assign w_empty = (i_count == '0);

    always_comb begin
        o_op     = OP_HOLD;
        o_status = ST_RANGE;
        w_at     = '0;
        unique case (i_cmd.action)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
                if (i_cmd.action == ACT_INS_HEAD) begin
                    w_at = '0;
                end else if (i_cmd.action == ACT_INS_TAIL) begin
                    w_at = w_cnt;
                end else begin
                    w_at = w_pos;
                end
                if (w_at > w_cnt) begin
                    o_status = ST_RANGE;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    o_status = ST_DONE;
                    o_op     = OP_INSERT;
                end
            end
            ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
                if (i_cmd.action == ACT_REM_HEAD) begin
                    w_at = '0;
                end else if (i_cmd.action == ACT_REM_TAIL) begin
                    w_at = w_cnt - CMP_W'(1);
                end else begin
                    w_at = w_pos;
                end
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (w_at >= w_cnt) begin
                    o_status = ST_RANGE;
                end else begin
                    o_status = ST_DONE;
                    o_op     = OP_REMOVE;
                end
            end
            default: begin
                o_status = ST_RANGE;
            end
        endcase
    end

    assign o_at = IDX_W'(w_at);

endmodule

`default_nettype wire

// ===== rtl/core/ple_checker.sv =====
// port level checks of the positional list engine and their bind
`default_nettype none

module ple_checker #(
    parameter int DEPTH = 16
) (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           start,
    input wire           busy,
    input wire           o_strobe,
    input ple_pkg::t_res o_res
);
    import ple_pkg::*;

    // one result beat for each accepted command, in the cycle after it is accepted
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_strobe == $past(start && !busy)))
        else $error("result beat does not match accepted command");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status != ST_DONE) |-> (o_res.removed_value == '0))
        else $error("failed command returned a handle");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_EMPTY) |-> (o_res.entry_count == '0))
        else $error("empty status with nonzero count");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && $past(i_rst_n) && o_res.status != ST_DONE)
        |-> (o_res.entry_count == $past(o_res.entry_count)))
        else $error("failed command changed the count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_res.entry_count) <= 32'(DEPTH)))
        else $error("count above depth");

endmodule

bind positional_list_engine_unit ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

`default_nettype wire
